/* rtl/page_frame_refcount_allocator_macros.svh */
// Assertion macros shared by the page frame allocator RTL.
`ifndef PAGE_FRAME_REFCOUNT_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_REFCOUNT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define PFRA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define PFRA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pfra_pkg.sv */
// Types, constants and codes shared by the page frame allocator modules.
`timescale 1ns / 1ps

package pfra_pkg;

	localparam int unsigned NUM_PAGES_DEF = 3840;
	localparam logic [31:0] LOW_MEMORY_BASE = 32'h0010_0000;
	localparam int unsigned PG_SHIFT = 12;
	// Width of a page number taken from a 32-bit address.
	localparam int unsigned PN_W = 32 - PG_SHIFT;
	localparam int unsigned WORD_W = 64;
	localparam int unsigned WORD_LG = 6;

	localparam logic [7:0] CNT_FREE = 8'd0;
	localparam logic [7:0] CNT_ONE = 8'd1;
	localparam logic [7:0] CNT_ABSENT = 8'd100;
	localparam logic [7:0] CNT_MAX = 8'd255;

	localparam logic [31:0] USABLE_START_RST = 32'h0010_0000;
	localparam logic [31:0] USABLE_END_RST = 32'h0100_0000;

	localparam logic CFG_USABLE_START = 1'b0;
	localparam logic CFG_USABLE_END = 1'b1;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NOFREE = 3'd1;
	localparam logic [2:0] ST_LOW = 3'd2;
	localparam logic [2:0] ST_HIGH = 3'd3;
	localparam logic [2:0] ST_ZERO = 3'd4;
	localparam logic [2:0] ST_SAT = 3'd5;

	typedef enum logic [1:0] {
		OP_INIT = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE = 2'd2,
		OP_SHARE = 2'd3
	} pfra_op_t;

	typedef struct packed {
		logic [1:0] op;
		logic [31:0] page_addr;
	} pfra_in_t;

	typedef struct packed {
		logic [31:0] result_addr;
		logic [2:0] status;
		logic [7:0] ref_count;
	} pfra_out_t;

	typedef struct packed {
		logic load;
		logic sweep;
		logic alloc_upd;
		logic acc_upd;
	} pfra_cmd_t;

	typedef struct packed {
		logic req_init;
		logic req_alloc;
		logic early_done;
		logic sweep_last;
	} pfra_sts_t;

endpackage

/* rtl/pfra_ctrl.sv */
// Controller state machine of the page frame allocator.
`timescale 1ns / 1ps

module pfra_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	input  pfra_pkg::pfra_sts_t   sts,
	output pfra_pkg::pfra_cmd_t   cmd
);
	import pfra_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SWEEP  = 6'b000010,
		S_ALLOC  = 6'b000100,
		S_ACC_RD = 6'b001000,
		S_ACC_WR = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic item_sweep_q;
	logic item_sweep_d;

	always_comb begin
		state_d = state_q;
		item_sweep_d = item_sweep_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (sts.req_init) begin
						state_d = S_SWEEP;
						item_sweep_d = 1'b1;
					end else if (sts.early_done) begin
						state_d = S_RESP;
					end else if (sts.req_alloc) begin
						state_d = S_ALLOC;
					end else begin
						state_d = S_ACC_RD;
					end
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					// The sweep after reset produces no word.
					state_d = item_sweep_q ? S_RESP : S_IDLE;
					item_sweep_d = 1'b0;
				end
			end
			S_ALLOC: begin
				cmd.alloc_upd = 1'b1;
				state_d = S_RESP;
			end
			S_ACC_RD: begin
				state_d = S_ACC_WR;
			end
			S_ACC_WR: begin
				cmd.acc_upd = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			item_sweep_q <= 1'b0;
		end else begin
			state_q <= state_d;
			item_sweep_q <= item_sweep_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

/* rtl/pfra_dp.sv */
// Datapath of the page frame allocator: count memory, free bitmap and result register.
`timescale 1ns / 1ps

module pfra_dp #(
	parameter int unsigned NUM_PAGES = pfra_pkg::NUM_PAGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pfra_pkg::pfra_in_t    req,
	output pfra_pkg::pfra_out_t   rsp,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [31:0]           cfg_data,
	input  pfra_pkg::pfra_cmd_t   cmd,
	output pfra_pkg::pfra_sts_t   sts
);
	import pfra_pkg::*;

	localparam int unsigned IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int unsigned NW = (NUM_PAGES + WORD_W - 1) / WORD_W;
	localparam int unsigned WIDX_W = (NW > 1) ? $clog2(NW) : 1;
	localparam logic [63:0] LIMIT =
		64'(LOW_MEMORY_BASE) + 64'(NUM_PAGES) * (64'd1 << PG_SHIFT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PAGES - 1);

	function automatic logic [WIDX_W-1:0] ffs_summary(input logic [NW-1:0] v);
		logic [WIDX_W-1:0] r;
		r = '0;
		for (int i = NW - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = WIDX_W'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [WORD_LG-1:0] ffs_word(input logic [WORD_W-1:0] v);
		logic [WORD_LG-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = WORD_LG'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [PN_W-1:0] page_of(input logic [31:0] x);
		logic [31:0] d;
		d = x - LOW_MEMORY_BASE;
		return (x < LOW_MEMORY_BASE) ? '0 : d[31:PG_SHIFT];
	endfunction

	// Configuration and per-item registers.
	logic [31:0] start_q;
	logic [31:0] end_q;
	logic [1:0] op_q;
	logic [IDX_W-1:0] idx_q;
	logic [WIDX_W-1:0] w_q;
	logic [PN_W-1:0] lo_q;
	logic [PN_W-1:0] hi_q;
	logic [IDX_W-1:0] cnt_q;
	logic [WORD_W-1:0] wacc_q;
	logic [NW-1:0] sum_q;
	pfra_out_t res_q;

	// Memories and their read registers.
	logic [7:0] cm_mem [NUM_PAGES];
	logic [WORD_W-1:0] bm_mem [NW];
	logic [7:0] cm_rd_q;
	logic [WORD_W-1:0] bm_rd_q;

	// Address check of the incoming word.
	logic [31:0] a_diff;
	logic [PN_W-1:0] a_page;
	logic [2:0] chk_st;
	logic [2:0] early_st;
	logic [WIDX_W-1:0] w_first;

	// Sweep signals.
	logic [PN_W-1:0] sw_page;
	logic [WORD_LG-1:0] sw_pos;
	logic [WIDX_W-1:0] sw_word;
	logic sw_free;
	logic [WORD_W-1:0] wacc_next;

	// Allocation signals.
	logic [WORD_LG-1:0] al_bit;
	logic [PN_W-1:0] al_page;
	logic [WORD_W-1:0] al_word;

	// Free and share signals.
	logic [PN_W-1:0] ac_page;
	logic [WORD_LG-1:0] ac_pos;
	logic [WIDX_W-1:0] ac_wd;
	logic [WORD_W-1:0] ac_bit;
	logic [WORD_W-1:0] ac_word;
	logic [7:0] ac_cnt;
	logic ac_cm_we;
	logic [2:0] ac_st;
	logic [7:0] ac_ref;

	// Write ports.
	logic cm_we;
	logic [IDX_W-1:0] cm_waddr;
	logic [7:0] cm_wdata;
	logic bm_we;
	logic [WIDX_W-1:0] bm_waddr;
	logic [WORD_W-1:0] bm_wdata;
	logic [WIDX_W-1:0] bm_raddr;

	always_comb begin
		a_diff = req.page_addr - LOW_MEMORY_BASE;
		a_page = a_diff[31:PG_SHIFT];
		if (req.page_addr < LOW_MEMORY_BASE) begin
			chk_st = ST_LOW;
		end else if (64'(req.page_addr) >= LIMIT) begin
			chk_st = ST_HIGH;
		end else begin
			chk_st = ST_OK;
		end
		w_first = ffs_summary(sum_q);
		case (pfra_op_t'(req.op))
			OP_INIT: early_st = ST_OK;
			OP_ALLOC: early_st = (sum_q == '0) ? ST_NOFREE : ST_OK;
			default: early_st = chk_st;
		endcase
	end

	assign sts.req_init = (pfra_op_t'(req.op) == OP_INIT);
	assign sts.req_alloc = (pfra_op_t'(req.op) == OP_ALLOC);
	assign sts.early_done = (early_st != ST_OK);
	assign sts.sweep_last = (cnt_q == LAST_IDX);

	// Sweep: one count per cycle, a bitmap word every WORD_W pages and at the last page.
	always_comb begin
		sw_page = PN_W'(cnt_q);
		sw_pos = sw_page[WORD_LG-1:0];
		sw_word = sw_page[WORD_LG +: WIDX_W];
		sw_free = (sw_page >= lo_q) && (sw_page < hi_q);
		wacc_next = ((sw_pos == '0) ? '0 : wacc_q) | (WORD_W'(sw_free) << sw_pos);
	end

	// Allocation from the bitmap word fetched at accept.
	always_comb begin
		al_bit = ffs_word(bm_rd_q);
		al_page = (PN_W'(w_q) << WORD_LG) | PN_W'(al_bit);
		al_word = bm_rd_q & ~(WORD_W'(1) << al_bit);
	end

	// Free and share on the fetched count.
	always_comb begin
		ac_page = PN_W'(idx_q);
		ac_pos = ac_page[WORD_LG-1:0];
		ac_wd = ac_page[WORD_LG +: WIDX_W];
		ac_bit = WORD_W'(1) << ac_pos;
		ac_word = bm_rd_q;
		ac_cnt = cm_rd_q;
		ac_cm_we = 1'b0;
		ac_st = ST_OK;
		ac_ref = CNT_FREE;
		if (pfra_op_t'(op_q) == OP_FREE) begin
			if (cm_rd_q == CNT_FREE) begin
				ac_st = ST_ZERO;
			end else begin
				ac_cnt = cm_rd_q - 8'd1;
				ac_cm_we = 1'b1;
				ac_ref = ac_cnt;
				if (ac_cnt == CNT_FREE) begin
					ac_word = bm_rd_q | ac_bit;
				end
			end
		end else begin
			if (cm_rd_q == CNT_MAX) begin
				ac_st = ST_SAT;
				ac_ref = CNT_MAX;
			end else begin
				ac_cnt = cm_rd_q + 8'd1;
				ac_cm_we = 1'b1;
				ac_ref = ac_cnt;
				if (cm_rd_q == CNT_FREE) begin
					ac_word = bm_rd_q & ~ac_bit;
				end
			end
		end
	end

	always_comb begin
		cm_we = 1'b0;
		cm_waddr = cnt_q;
		cm_wdata = sw_free ? CNT_FREE : CNT_ABSENT;
		bm_we = 1'b0;
		bm_waddr = sw_word;
		bm_wdata = wacc_next;
		if (cmd.sweep) begin
			cm_we = 1'b1;
			bm_we = (sw_pos == WORD_LG'(WORD_W - 1)) || (cnt_q == LAST_IDX);
		end else if (cmd.alloc_upd) begin
			cm_we = 1'b1;
			cm_waddr = al_page[IDX_W-1:0];
			cm_wdata = CNT_ONE;
			bm_we = 1'b1;
			bm_waddr = w_q;
			bm_wdata = al_word;
		end else if (cmd.acc_upd) begin
			cm_we = ac_cm_we;
			cm_waddr = idx_q;
			cm_wdata = ac_cnt;
			bm_we = 1'b1;
			bm_waddr = ac_wd;
			bm_wdata = ac_word;
		end
		bm_raddr = cmd.load ? w_first : ac_wd;
	end

	always_ff @(posedge clk) begin
		if (cm_we) begin
			cm_mem[cm_waddr] <= cm_wdata;
		end
		cm_rd_q <= cm_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_waddr] <= bm_wdata;
		end
		bm_rd_q <= bm_mem[bm_raddr];
	end

	// The summary holds one bit per bitmap word that still has a free page.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (bm_we) begin
			sum_q[bm_waddr] <= (bm_wdata != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= USABLE_START_RST;
			end_q <= USABLE_END_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_USABLE_START: start_q <= cfg_data;
				CFG_USABLE_END: end_q <= cfg_data;
				default: start_q <= start_q;
			endcase
		end
	end

	// An empty range at reset makes the first sweep mark every page absent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
			if (pfra_op_t'(req.op) == OP_INIT) begin
				lo_q <= page_of(start_q);
				hi_q <= page_of(end_q);
			end
		end else if (cmd.sweep) begin
			cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			wacc_q <= wacc_next;
		end
		if (cmd.load) begin
			op_q <= req.op;
			idx_q <= a_page[IDX_W-1:0];
			w_q <= w_first;
			res_q.result_addr <= '0;
			res_q.status <= early_st;
			res_q.ref_count <= CNT_FREE;
		end else if (cmd.alloc_upd) begin
			res_q.result_addr <= LOW_MEMORY_BASE + (32'(al_page) << PG_SHIFT);
			res_q.status <= ST_OK;
			res_q.ref_count <= CNT_ONE;
		end else if (cmd.acc_upd) begin
			res_q.result_addr <= '0;
			res_q.status <= ac_st;
			res_q.ref_count <= ac_ref;
		end
	end

	assign rsp = res_q;

endmodule

/* rtl/page_frame_refcount_allocator.sv */
// Top level of the reference-counted page frame allocator.
// A new word is taken in the cycle after done.
// The count and bitmap reads are registered; init sweeps one page a cycle.
// After reset the block sweeps all NUM_PAGES counts to absent and stays busy while it does so.
// The receiver cannot stall: each result stands for one cycle with done high.
`timescale 1ns / 1ps
`include "page_frame_refcount_allocator_macros.svh"

module page_frame_refcount_allocator #(
	parameter int unsigned NUM_PAGES = pfra_pkg::NUM_PAGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	input  pfra_pkg::pfra_in_t    req,
	output pfra_pkg::pfra_out_t   rsp,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [31:0]           cfg_data
);
	import pfra_pkg::*;

	pfra_cmd_t cmd;
	pfra_sts_t sts;

	pfra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	pfra_dp #(
		.NUM_PAGES (NUM_PAGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	`PFRA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`PFRA_ASSERT_NXT(a_done_idle, done, !busy, "block not idle after result")
	`PFRA_ASSERT_IMP(a_nofree_zero, done && (rsp.status == ST_NOFREE), (rsp.result_addr == '0) && (rsp.ref_count == CNT_FREE), "no-free result carries data")
	`PFRA_ASSERT_IMP(a_alloc_one, done && (rsp.result_addr != '0), (rsp.ref_count == CNT_ONE) && (rsp.status == ST_OK), "allocation result count is not one")

endmodule

/* sim/page_frame_refcount_allocator_test.sv */
// Self-checking testbench for the reference-counted page frame allocator.
`timescale 1ns / 1ps

module page_frame_refcount_allocator_test;
	import pfra_pkg::*;

	localparam int unsigned PAGES = NUM_PAGES_DEF;
	localparam int unsigned PAGE_BYTES = 32'h1000;
	localparam logic [31:0] PAGE_LIMIT = LOW_MEMORY_BASE + PAGES * PAGE_BYTES;
	localparam int unsigned STALL_LIMIT = 40000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	pfra_in_t req = '0;
	pfra_out_t rsp;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_USABLE_START;
	logic [31:0] cfg_data = '0;

	// Predictor state: one reference count per frame plus the usable range registers.
	logic [7:0] frame_refs [PAGES];
	logic [31:0] usable_start_cfg = USABLE_START_RST;
	logic [31:0] usable_end_cfg = USABLE_END_RST;
	int unsigned usable_lo_page = 0;
	pfra_out_t pending_results [$];
	int mismatch_count = 0;
	int burst_left = 0;

	page_frame_refcount_allocator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned page_index(logic [31:0] addr);
		if (addr < LOW_MEMORY_BASE)
			return 0;
		return (addr - LOW_MEMORY_BASE) >> PG_SHIFT;
	endfunction

	function automatic pfra_out_t predict_page_op(pfra_in_t item);
		pfra_out_t r;
		int unsigned lo;
		int unsigned hi;
		int unsigned pg;
		int unsigned i;
		bit found;
		r = '0;
		pg = 0;
		case (pfra_op_t'(item.op))
		OP_INIT: begin
			lo = page_index(usable_start_cfg);
			hi = page_index(usable_end_cfg);
			for (i = 0; i < PAGES; i++)
				frame_refs[i] = (i >= lo && i < hi) ? CNT_FREE : CNT_ABSENT;
			usable_lo_page = lo;
		end
		OP_ALLOC: begin
			found = 1'b0;
			for (i = 0; i < PAGES && !found; i++) begin
				if (frame_refs[i] == CNT_FREE) begin
					found = 1'b1;
					pg = i;
				end
			end
			if (found) begin
				frame_refs[pg] = CNT_ONE;
				r.result_addr = LOW_MEMORY_BASE + pg * PAGE_BYTES;
				r.ref_count = CNT_ONE;
			end else begin
				r.status = ST_NOFREE;
			end
		end
		default: begin
			if (item.page_addr < LOW_MEMORY_BASE) begin
				r.status = ST_LOW;
			end else if (item.page_addr >= PAGE_LIMIT) begin
				r.status = ST_HIGH;
			end else begin
				pg = page_index(item.page_addr);
				if (item.op == OP_FREE) begin
					if (frame_refs[pg] == CNT_FREE) begin
						r.status = ST_ZERO;
					end else begin
						frame_refs[pg] = frame_refs[pg] - 8'd1;
						r.ref_count = frame_refs[pg];
					end
				end else if (frame_refs[pg] == CNT_MAX) begin
					r.status = ST_SAT;
					r.ref_count = CNT_MAX;
				end else begin
					frame_refs[pg] = frame_refs[pg] + 8'd1;
					r.ref_count = frame_refs[pg];
				end
			end
		end
		endcase
		return r;
	endfunction

	// Start stays high from one word to the next inside a burst; gaps come between bursts.
	task automatic send_word(input pfra_op_t op, input logic [31:0] addr);
		pfra_in_t item;
		item.op = op;
		item.page_addr = addr;
		start <= 1'b1;
		req <= item;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_page_op(item));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_config(input logic [31:0] lo_addr, input logic [31:0] hi_addr);
		cfg_we <= 1'b1;
		cfg_index <= CFG_USABLE_START;
		cfg_data <= lo_addr;
		@(posedge clk);
		cfg_index <= CFG_USABLE_END;
		cfg_data <= hi_addr;
		@(posedge clk);
		cfg_we <= 1'b0;
		usable_start_cfg = lo_addr;
		usable_end_cfg = hi_addr;
	endtask

	function automatic pfra_op_t pick_op();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 2)
			return OP_INIT;
		if (sel < 37)
			return OP_ALLOC;
		if (sel < 70)
			return OP_FREE;
		return OP_SHARE;
	endfunction

	// Most addresses land near the bottom of the usable range, where allocation happens.
	function automatic logic [31:0] pick_addr();
		int unsigned pg;
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			pg = (usable_lo_page < PAGES) ? usable_lo_page : 0;
			pg = pg + $urandom_range(0, 15);
			if (pg >= PAGES)
				pg = PAGES - 1;
			return LOW_MEMORY_BASE + pg * PAGE_BYTES + $urandom_range(0, 4095);
		end
		if (sel < 75)
			return LOW_MEMORY_BASE + $urandom_range(0, PAGES - 1) * PAGE_BYTES
				+ $urandom_range(0, 4095);
		if (sel < 90)
			return $urandom;
		case ($urandom_range(0, 4))
		0: return 32'h0;
		1: return LOW_MEMORY_BASE - 32'd1;
		2: return PAGE_LIMIT;
		3: return PAGE_LIMIT - 32'd1;
		default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	task automatic test_reset_state();
		// Every frame is absent after reset, so nothing can be allocated yet.
		send_word(OP_ALLOC, 32'hFFFF_FFFF);
		send_word(OP_FREE, LOW_MEMORY_BASE);
		send_word(OP_SHARE, LOW_MEMORY_BASE + 32'hABC);
		send_word(OP_FREE, LOW_MEMORY_BASE - 32'd1);
		send_word(OP_SHARE, 32'h0);
		send_word(OP_FREE, PAGE_LIMIT);
		send_word(OP_SHARE, 32'hFFFF_FFFF);
		send_word(OP_FREE, PAGE_LIMIT - 32'd1);
	endtask

	task automatic test_alloc_free();
		send_word(OP_INIT, 32'h0);
		repeat (3) send_word(OP_ALLOC, $urandom);
		send_word(OP_FREE, LOW_MEMORY_BASE + 32'h1FFF);
		send_word(OP_ALLOC, 32'h0);
		send_word(OP_FREE, LOW_MEMORY_BASE + 32'h3000);
		send_word(OP_SHARE, LOW_MEMORY_BASE);
		send_word(OP_FREE, LOW_MEMORY_BASE);
	endtask

	task automatic test_config_extremes();
		wait_idle();
		write_config(32'hFFFF_FFFF, 32'h0);
		send_word(OP_INIT, 32'h0);
		send_word(OP_ALLOC, 32'h0);
		wait_idle();
		write_config(32'h0, 32'hFFFF_FFFF);
		send_word(OP_INIT, 32'hFFFF_FFFF);
		send_word(OP_ALLOC, 32'h0);
		wait_idle();
		write_config(LOW_MEMORY_BASE + 32'h5000, LOW_MEMORY_BASE + 32'h6000);
		send_word(OP_INIT, 32'h0);
		repeat (2) send_word(OP_ALLOC, 32'h0);
	endtask

	task automatic test_share_saturation();
		// Frame 10 is absent here; sharing climbs from 100 and sticks at the top.
		repeat (157)
			send_word(OP_SHARE, LOW_MEMORY_BASE + 10 * PAGE_BYTES + $urandom_range(0, 4095));
		send_word(OP_FREE, LOW_MEMORY_BASE + 10 * PAGE_BYTES);
	endtask

	task automatic test_random_ops();
		logic [31:0] lo_addr;
		logic [31:0] hi_addr;
		for (int p = 0; p < 6; p++) begin
			case (p)
			1: begin
				lo_addr = $urandom_range(0, LOW_MEMORY_BASE - 1);
				hi_addr = LOW_MEMORY_BASE + $urandom_range(4, 24) * PAGE_BYTES;
			end
			2: begin
				lo_addr = $urandom;
				hi_addr = $urandom;
			end
			3: begin
				lo_addr = PAGE_LIMIT - $urandom_range(2, 10) * PAGE_BYTES;
				hi_addr = $urandom_range(PAGE_LIMIT, 32'hFFFF_FFFF);
			end
			4: begin
				lo_addr = 32'h0;
				hi_addr = 32'hFFFF_FFFF;
			end
			default: begin
				lo_addr = LOW_MEMORY_BASE + $urandom_range(0, PAGES - 20) * PAGE_BYTES
					+ $urandom_range(0, 4095);
				hi_addr = lo_addr + $urandom_range(1, 12) * PAGE_BYTES;
			end
			endcase
			wait_idle();
			write_config(lo_addr, hi_addr);
			send_word(OP_INIT, $urandom);
			repeat (46) send_word(pick_op(), pick_addr());
		end
	endtask

	always @(posedge clk) begin
		pfra_out_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result word: result_addr %h status %0d ref_count %0d",
					rsp.result_addr, rsp.status, rsp.ref_count);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp.result_addr !== want.result_addr) begin
					$error("result_addr: expected %h, actual %h", want.result_addr, rsp.result_addr);
					mismatch_count++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					mismatch_count++;
				end
				if (rsp.ref_count !== want.ref_count) begin
					$error("ref_count: expected %0d, actual %0d", want.ref_count, rsp.ref_count);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		for (int i = 0; i < PAGES; i++)
			frame_refs[i] = CNT_ABSENT;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// The block marks every count absent after reset before it takes the first word.
		wait_idle();
		test_reset_state();
		test_alloc_free();
		test_config_extremes();
		test_share_saturation();
		test_random_ops();
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
